FILE: rtl/assert_macros.svh
// Assertion helper macros shared by the checker files.
// Needs a clock and an active-low reset name at each use site.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mbe_pkg.sv
// Shared types and constants of the multibrot escape-time block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mbe_pkg;

    localparam int COORD_W    = 32;
    localparam int PROD_W     = 64;
    localparam int DEGREE_W   = 4;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic [DEGREE_W-1:0]       degree_t;

    // Register index, taken from paddr[2]
    typedef enum logic
    {
        REG_MAX_ITER = 1'b0,
        REG_DEGREE   = 1'b1
    } reg_idx_t;

    typedef enum logic [4:0]
    {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_ADD  = 5'b00100,
        ST_MAG  = 5'b01000,
        ST_OUT  = 5'b10000
    } seq_state_t;

endpackage

FILE: rtl/mbe_mul.sv
// Shared 32x32 signed multiplier with a registered 64-bit product.
// Depends on mbe_pkg for the operand and product types.
`timescale 1ns / 1ps

module mbe_mul
(
    input  logic           clk,
    input  mbe_pkg::coord_t a,
    input  mbe_pkg::coord_t b,
    output mbe_pkg::prod_t  prod
);
    import mbe_pkg::*;

    prod_t prod_reg;
    prod_t prod_next;

    assign prod_next = prod_t'(a) * prod_t'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/mbe_regs.sv
// APB configuration registers: iteration limit and exponent.
// Depends on mbe_pkg for register indexes and bus widths.
`timescale 1ns / 1ps

module mbe_regs
#(
    parameter int MAX_DEGREE = 8,
    parameter int COUNT_BITS = 16,
    parameter int MI_W       = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mbe_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mbe_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mbe_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output logic [MI_W-1:0]                max_iter,
    output mbe_pkg::degree_t               degree
);
    import mbe_pkg::*;

    localparam logic [MI_W-1:0] MAX_ITER_RST = MI_W'(256);
    localparam degree_t         DEGREE_RST   = DEGREE_W'(2);
    localparam degree_t         DEGREE_MIN   = DEGREE_W'(2);

    logic [MI_W-1:0]       max_iter_reg;
    logic [MI_W-1:0]       max_iter_next;
    degree_t               degree_reg;
    degree_t               degree_next;
    logic                  wr_en;
    reg_idx_t              idx;
    logic [COUNT_BITS-1:0] wr_iter;
    degree_t               wr_degree;

    assign pready    = 1'b1;
    assign wr_en     = psel & penable & pwrite & pready;
    assign idx       = reg_idx_t'(paddr[2]);
    assign wr_iter   = pwdata[COUNT_BITS-1:0];
    assign wr_degree = pwdata[DEGREE_W-1:0];

    // Drop writes of a zero limit or an exponent out of range
    always_comb
    begin
        max_iter_next = max_iter_reg;
        degree_next   = degree_reg;
        if (wr_en)
        begin
            case (idx)
                REG_MAX_ITER:
                begin
                    if (wr_iter != '0)
                        max_iter_next = MI_W'(wr_iter);
                end
                REG_DEGREE:
                begin
                    if (wr_degree >= DEGREE_MIN && 32'(wr_degree) <= MAX_DEGREE)
                        degree_next = wr_degree;
                end
                default:
                begin
                    max_iter_next = max_iter_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_MAX_ITER: prdata = APB_DATA_W'(max_iter_reg);
            REG_DEGREE:   prdata = APB_DATA_W'(degree_reg);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= MAX_ITER_RST;
            degree_reg   <= DEGREE_RST;
        end
        else
        begin
            max_iter_reg <= max_iter_next;
            degree_reg   <= degree_next;
        end
    end

    assign max_iter = max_iter_reg;
    assign degree   = degree_reg;

endmodule

FILE: rtl/mbe_seq.sv
// Iteration sequencer and datapath around the shared multiplier.
// Depends on mbe_pkg and instantiates mbe_mul.
`timescale 1ns / 1ps

module mbe_seq
#(
    parameter int FRAC_BITS = 28,
    parameter int MI_W      = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [MI_W-1:0]  max_iter,
    input  mbe_pkg::degree_t degree,
    input  logic             in_valid,
    output logic             in_ready,
    input  mbe_pkg::coord_t  c_re,
    input  mbe_pkg::coord_t  c_im,
    output logic             res_valid,
    input  logic             res_ready,
    output logic [MI_W-1:0]  res_count,
    output logic             res_escaped
);
    import mbe_pkg::*;

    // Product phases of one complex multiply, and of the magnitude check
    localparam logic [2:0] PH_AC  = 3'd0;
    localparam logic [2:0] PH_BD  = 3'd1;
    localparam logic [2:0] PH_AD  = 3'd2;
    localparam logic [2:0] PH_BC  = 3'd3;
    localparam logic [2:0] PH_IM  = 3'd4;
    localparam logic [2:0] PH_RE2 = 3'd0;
    localparam logic [2:0] PH_IM2 = 3'd1;

    localparam bit HAVE_LIMIT = (2 * FRAC_BITS + 2) < 64;
    localparam logic [PROD_W:0] MAG_LIMIT =
        HAVE_LIMIT ? ((PROD_W+1)'(4) << (2 * FRAC_BITS)) : '0;

    // Clamp the exact sum to 64 bits with saturation, floor-shift, clamp to 32
    function automatic logic [COORD_W:0] prod_to_coord(input logic signed [PROD_W:0] s);
        logic signed [PROD_W-1:0] s64;
        logic signed [PROD_W-1:0] sh;
        logic [COORD_W:0]         r;
        begin
            if (s[PROD_W] != s[PROD_W-1])
                s64 = s[PROD_W] ? {1'b1, {(PROD_W-1){1'b0}}} : {1'b0, {(PROD_W-1){1'b1}}};
            else
                s64 = s[PROD_W-1:0];
            sh = s64 >>> FRAC_BITS;
            if (sh > PROD_W'(64'sd2147483647))
                r = {1'b1, 1'b0, {(COORD_W-1){1'b1}}};
            else if (sh < -64'sd2147483648)
                r = {1'b1, 1'b1, {(COORD_W-1){1'b0}}};
            else
                r = {1'b0, sh[COORD_W-1:0]};
            return r;
        end
    endfunction

    function automatic logic [COORD_W:0] add_clamp(input coord_t a, input coord_t b);
        logic signed [COORD_W:0] s;
        logic [COORD_W:0]        r;
        begin
            s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
            if (s[COORD_W] != s[COORD_W-1])
                r = {1'b1, s[COORD_W], {(COORD_W-1){~s[COORD_W]}}};
            else
                r = {1'b0, s[COORD_W-1:0]};
            return r;
        end
    endfunction

    seq_state_t      state_reg, state_next;
    logic [2:0]      ph_reg, ph_next;
    degree_t         k_reg, k_next;
    logic [MI_W-1:0] iter_reg, iter_next;
    coord_t          c_re_reg, c_re_next;
    coord_t          c_im_reg, c_im_next;
    coord_t          z_re_reg, z_re_next;
    coord_t          z_im_reg, z_im_next;
    coord_t          acc_re_reg, acc_re_next;
    coord_t          acc_im_reg, acc_im_next;
    coord_t          tmp_re_reg, tmp_re_next;
    prod_t           sum_reg, sum_next;
    logic            sat_reg, sat_next;
    logic [MI_W-1:0] count_reg, count_next;
    logic            esc_reg, esc_next;

    coord_t            mul_a;
    coord_t            mul_b;
    prod_t             prod;
    logic [COORD_W:0]  cm_diff;
    logic [COORD_W:0]  cm_sum;
    logic [COORD_W:0]  add_re;
    logic [COORD_W:0]  add_im;
    logic [PROD_W:0]   mag;
    logic              last_mul;
    logic              last_iter;
    logic              escape;

    mbe_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign cm_diff   = prod_to_coord({sum_reg[PROD_W-1], sum_reg} - {prod[PROD_W-1], prod});
    assign cm_sum    = prod_to_coord({sum_reg[PROD_W-1], sum_reg} + {prod[PROD_W-1], prod});
    assign add_re    = add_clamp(acc_re_reg, c_re_reg);
    assign add_im    = add_clamp(acc_im_reg, c_im_reg);
    // Both squares are non-negative, so add them as unsigned
    assign mag       = {1'b0, sum_reg} + {1'b0, prod};
    assign last_mul  = ({1'b0, k_reg} + (DEGREE_W+1)'(1)) == {1'b0, degree};
    assign last_iter = ({1'b0, iter_reg} + (MI_W+1)'(1)) == {1'b0, max_iter};
    assign escape    = sat_reg || (HAVE_LIMIT && (mag > MAG_LIMIT));

    always_comb
    begin
        state_next  = state_reg;
        ph_next     = ph_reg;
        k_next      = k_reg;
        iter_next   = iter_reg;
        c_re_next   = c_re_reg;
        c_im_next   = c_im_reg;
        z_re_next   = z_re_reg;
        z_im_next   = z_im_reg;
        acc_re_next = acc_re_reg;
        acc_im_next = acc_im_reg;
        tmp_re_next = tmp_re_reg;
        sum_next    = sum_reg;
        sat_next    = sat_reg;
        count_next  = count_reg;
        esc_next    = esc_reg;
        mul_a       = acc_re_reg;
        mul_b       = z_re_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    c_re_next   = c_re;
                    c_im_next   = c_im;
                    z_re_next   = '0;
                    z_im_next   = '0;
                    acc_re_next = '0;
                    acc_im_next = '0;
                    iter_next   = '0;
                    k_next      = DEGREE_W'(1);
                    ph_next     = PH_AC;
                    sat_next    = 1'b0;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                case (ph_reg)
                    PH_AC:
                    begin
                        mul_a   = acc_re_reg;
                        mul_b   = z_re_reg;
                        ph_next = PH_BD;
                    end
                    PH_BD:
                    begin
                        mul_a    = acc_im_reg;
                        mul_b    = z_im_reg;
                        sum_next = prod;
                        ph_next  = PH_AD;
                    end
                    PH_AD:
                    begin
                        mul_a       = acc_re_reg;
                        mul_b       = z_im_reg;
                        tmp_re_next = cm_diff[COORD_W-1:0];
                        sat_next    = sat_reg | cm_diff[COORD_W];
                        ph_next     = PH_BC;
                    end
                    PH_BC:
                    begin
                        mul_a    = acc_im_reg;
                        mul_b    = z_re_reg;
                        sum_next = prod;
                        ph_next  = PH_IM;
                    end
                    default:
                    begin
                        acc_re_next = tmp_re_reg;
                        acc_im_next = cm_sum[COORD_W-1:0];
                        sat_next    = sat_reg | cm_sum[COORD_W];
                        ph_next     = PH_AC;
                        if (last_mul)
                            state_next = ST_ADD;
                        else
                            k_next = k_reg + DEGREE_W'(1);
                    end
                endcase
            end
            ST_ADD:
            begin
                z_re_next   = add_re[COORD_W-1:0];
                z_im_next   = add_im[COORD_W-1:0];
                acc_re_next = add_re[COORD_W-1:0];
                acc_im_next = add_im[COORD_W-1:0];
                sat_next    = sat_reg | add_re[COORD_W] | add_im[COORD_W];
                ph_next     = PH_RE2;
                state_next  = ST_MAG;
            end
            ST_MAG:
            begin
                case (ph_reg)
                    PH_RE2:
                    begin
                        mul_a   = z_re_reg;
                        mul_b   = z_re_reg;
                        ph_next = PH_IM2;
                    end
                    PH_IM2:
                    begin
                        mul_a    = z_im_reg;
                        mul_b    = z_im_reg;
                        sum_next = prod;
                        ph_next  = PH_IM;
                    end
                    default:
                    begin
                        ph_next = PH_AC;
                        if (escape)
                        begin
                            count_next = iter_reg;
                            esc_next   = 1'b1;
                            state_next = ST_OUT;
                        end
                        else if (last_iter)
                        begin
                            count_next = max_iter;
                            esc_next   = 1'b0;
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            iter_next  = iter_reg + MI_W'(1);
                            k_next     = DEGREE_W'(1);
                            sat_next   = 1'b0;
                            state_next = ST_MUL;
                        end
                    end
                endcase
            end
            ST_OUT:
            begin
                if (res_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ph_reg    <= PH_AC;
            k_reg     <= '0;
            iter_reg  <= '0;
            sat_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            k_reg     <= k_next;
            iter_reg  <= iter_next;
            sat_reg   <= sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_re_reg   <= c_re_next;
        c_im_reg   <= c_im_next;
        z_re_reg   <= z_re_next;
        z_im_reg   <= z_im_next;
        acc_re_reg <= acc_re_next;
        acc_im_reg <= acc_im_next;
        tmp_re_reg <= tmp_re_next;
        sum_reg    <= sum_next;
        count_reg  <= count_next;
        esc_reg    <= esc_next;
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign res_valid   = (state_reg == ST_OUT);
    assign res_count   = count_reg;
    assign res_escaped = esc_reg;

endmodule

FILE: rtl/multibrot_escape_time.sv
// Top level of the multibrot escape-time block: stream ports, APB registers,
// output register. Depends on mbe_pkg, mbe_regs, mbe_seq (and mbe_mul below it).
`timescale 1ns / 1ps

// Usage
//   Input stream (s_t*): one request per point c, c_re in s_tdata[31:0] and
//   c_im in s_tdata[63:32], both signed with FRAC_BITS fraction bits.
//   Output stream (m_t*): m_tdata holds the escape count (zero-based index of
//   the escaping iteration, or max_iterations when the point stays bounded);
//   m_tuser is the escaped flag.
//   APB port: register 0 (byte 0) is max_iterations, register 1 (byte 4) is
//   degree. Writes of a zero limit or a degree outside 2..MAX_DEGREE are
//   dropped. Write only while no point is in flight.
// Datapath
//   One shared 32x32 multiplier does all the work. An iteration runs degree-1
//   complex multiplies by z, then adds c and checks the magnitude. A point shows
//   on m_tvalid once its iterations end and the output register is free; s_tready
//   rises with it, so a new request is taken only after the last result has left
//   the sequencer.
// Reset and stalls
//   Reset returns the registers to max_iterations=256, degree=2, and empties
//   the sequencer and the output register. A stalled receiver holds the result
//   in the output register; the next point is still accepted meanwhile, and
//   the sequencer holds its finished result until the output register frees.
module multibrot_escape_time
#(
    parameter int MAX_DEGREE = 8,
    parameter int FRAC_BITS  = 28,
    parameter int COUNT_BITS = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // APB configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mbe_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mbe_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mbe_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    // Point stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [2*mbe_pkg::COORD_W-1:0]     s_tdata,   // c_re [31:0], c_im [63:32]
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [((COUNT_BITS+7)/8)*8-1:0]   m_tdata,   // escape_count [COUNT_BITS-1:0]
    output logic                              m_tuser    // escaped [0]
);
    import mbe_pkg::*;

    localparam int OUT_W = ((COUNT_BITS + 7) / 8) * 8;
    // Iteration counter wide enough for the reset limit of 256
    localparam int MI_W  = (COUNT_BITS > 9) ? COUNT_BITS : 9;

    logic [MI_W-1:0]       max_iter;
    degree_t               degree;
    logic                  res_valid;
    logic                  res_ready;
    logic [MI_W-1:0]       res_count;
    logic                  res_escaped;

    logic                  m_valid_reg, m_valid_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  esc_reg, esc_next;
    logic                  load;

    mbe_regs
    #(
        .MAX_DEGREE (MAX_DEGREE),
        .COUNT_BITS (COUNT_BITS),
        .MI_W       (MI_W)
    )
    u_regs
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .max_iter (max_iter),
        .degree   (degree)
    );

    mbe_seq
    #(
        .FRAC_BITS (FRAC_BITS),
        .MI_W      (MI_W)
    )
    u_seq
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .max_iter    (max_iter),
        .degree      (degree),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .c_re        (s_tdata[COORD_W-1:0]),
        .c_im        (s_tdata[2*COORD_W-1:COORD_W]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_count   (res_count),
        .res_escaped (res_escaped)
    );

    // Output register frees when empty or when the receiver takes its result
    assign res_ready = !m_valid_reg || m_tready;
    assign load      = res_valid && res_ready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        count_next   = count_reg;
        esc_next     = esc_reg;
        if (load)
        begin
            m_valid_next = 1'b1;
            // Drop the bits above the count width
            count_next   = res_count[COUNT_BITS-1:0];
            esc_next     = res_escaped;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        esc_reg   <= esc_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'(count_reg);
    assign m_tuser  = esc_reg;

endmodule

FILE: rtl/mbe_checker.sv
// Port-level checker for the multibrot escape-time block, bound to the top.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mbe_checker
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pready,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [((COUNT_BITS+7)/8)*8-1:0] m_tdata,
    input  logic                            m_tuser
);

    // A point keeps the block busy in the cycle after its request
    `ASSERT_NEXT(a_busy_after_req, clk, rst_n, s_tvalid && s_tready, !s_tready, "ready after request")

    // A new result only follows a cycle in which the sequencer was busy
    `ASSERT_IMPLIES(a_result_from_busy, clk, rst_n, $rose(m_tvalid), $past(!s_tready), "result from idle")

    // Hold a stalled result unchanged
    `ASSERT_NEXT(a_stall_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // Register access never waits
    `ASSERT_IMPLIES(a_pready_high, clk, rst_n, 1'b1, pready, "pready low")

endmodule

bind multibrot_escape_time mbe_checker
#(
    .COUNT_BITS (COUNT_BITS)
)
u_mbe_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: tb/multibrot_escape_time_test.sv
// Self-checking testbench for the multibrot escape-time block.
// Needs mbe_pkg and the multibrot_escape_time RTL; drives the point stream and the
// APB registers, and predicts every escape count with its own fixed-point iterator.
`timescale 1ns / 1ps

module multibrot_escape_time_test;

    import mbe_pkg::*;

    localparam int MAX_DEGREE = 8;
    localparam int FRAC_BITS  = 28;
    localparam int COUNT_BITS = 16;
    localparam int OUT_W      = ((COUNT_BITS + 7) / 8) * 8;

    // Wide signed type for exact products and sums of 32-bit coordinates
    typedef logic signed [65:0] wide_t;

    localparam wide_t WIDE_MAX  = (66'sd1 <<< 63) - 66'sd1;
    localparam wide_t WIDE_MIN  = -(66'sd1 <<< 63);
    localparam wide_t COORD_MAX = 66'sd2147483647;
    localparam wide_t COORD_MIN = -66'sd2147483648;
    // Escape radius: |z|^2 > 4 at the scale of a squared coordinate
    localparam wide_t MAG_LIMIT = 66'sd4 <<< (2 * FRAC_BITS);

    // Handy Q4.28 coordinates
    localparam coord_t Q_ZERO    = 32'sd0;
    localparam coord_t Q_ONE     = 32'sh1000_0000;
    localparam coord_t Q_TWO     = 32'sh2000_0000;
    localparam coord_t Q_NEG_TWO = 32'shE000_0000;
    localparam coord_t Q_ONE_P5  = 32'sh1800_0000;
    localparam coord_t Q_TWO_P5  = 32'sh2800_0000;
    localparam coord_t Q_NEG_3Q  = 32'shF400_0000;   // -0.75
    localparam coord_t Q_TENTH   = 32'sd26843546;    // 0.1
    localparam coord_t Q_0_26    = 32'sd69793219;    // just past the cusp at 0.25
    localparam coord_t Q_0_9     = 32'sd241591910;
    localparam coord_t Q_1_2     = 32'sd322122547;
    localparam coord_t Q_1_9     = 32'sd510027366;
    localparam coord_t Q_MAX     = 32'sh7FFF_FFFF;
    localparam coord_t Q_MIN     = 32'sh8000_0000;

    localparam int RANDOM_PHASES    = 12;
    localparam int POINTS_PER_PHASE = 85;

    typedef struct packed
    {
        logic [COUNT_BITS-1:0] count;
        logic                  escaped;
    } escape_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [2*COORD_W-1:0]  s_tdata;    // c_re [31:0], c_im [63:32]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_W-1:0]      m_tdata;    // escape_count [15:0]
    logic                  m_tuser;    // escaped [0]

    // Shadow copy of the two registers, updated by the same rules as the block
    logic [COUNT_BITS-1:0] cfg_max_iter = 16'd256;
    degree_t               cfg_degree   = 4'd2;

    escape_t     expected_escapes[$];
    int unsigned rx_hold_cycles = 0;    // long receiver stall, counted by the receiver
    bit          no_idle        = 1'b0; // run both sides without gaps
    int unsigned points_sent    = 0;
    int unsigned results_seen   = 0;
    int unsigned settings_used  = 0;
    int unsigned mismatch_count = 0;

    multibrot_escape_time
    #(
        .MAX_DEGREE (MAX_DEGREE),
        .FRAC_BITS  (FRAC_BITS),
        .COUNT_BITS (COUNT_BITS)
    )
    dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 4 ns clock
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Clamp to the 32-bit coordinate range and flag any clamping.
    function automatic wide_t clamp_coord(wide_t v, inout bit sat);
        if (v > COORD_MAX)
        begin
            sat = 1'b1;
            return COORD_MAX;
        end
        if (v < COORD_MIN)
        begin
            sat = 1'b1;
            return COORD_MIN;
        end
        return v;
    endfunction

    // One component of a complex product: clamp the raw sum to 64 bits,
    // drop the fraction bits toward minus infinity, then clamp to 32 bits.
    function automatic wide_t fixed_product(wide_t raw, inout bit sat);
        wide_t v;
        v = raw;
        if (v > WIDE_MAX)
            v = WIDE_MAX;
        else if (v < WIDE_MIN)
            v = WIDE_MIN;
        v = v >>> FRAC_BITS;
        return clamp_coord(v, sat);
    endfunction

    // Iterate z = z^degree + c from z = 0 under the current register values.
    function automatic escape_t predict_escape(coord_t c_re, coord_t c_im);
        escape_t res;
        wide_t   z_re;
        wide_t   z_im;
        wide_t   acc_re;
        wide_t   acc_im;
        wide_t   nxt_re;
        wide_t   mag;
        bit      sat;
        res.count   = cfg_max_iter;
        res.escaped = 1'b0;
        z_re = '0;
        z_im = '0;
        for (int unsigned it = 0; it < cfg_max_iter; it++)
        begin
            sat    = 1'b0;
            acc_re = z_re;
            acc_im = z_im;
            // degree-1 complex multiplies by z
            for (int k = 1; k < cfg_degree; k++)
            begin
                nxt_re = fixed_product(acc_re * z_re - acc_im * z_im, sat);
                acc_im = fixed_product(acc_re * z_im + acc_im * z_re, sat);
                acc_re = nxt_re;
            end
            z_re = clamp_coord(acc_re + c_re, sat);
            z_im = clamp_coord(acc_im + c_im, sat);
            mag  = z_re * z_re + z_im * z_im;
            // Saturation anywhere in the iteration counts as escape too
            if (sat || mag > MAG_LIMIT)
            begin
                res.count   = COUNT_BITS'(it);
                res.escaped = 1'b1;
                break;
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(12, 40);
    endfunction

    // Mostly the interesting box around the set, some full-range noise,
    // and some points near the origin that tend to stay bounded.
    function automatic coord_t rand_coord();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return coord_t'(int'($urandom_range(0, 32'h4800_0000)) - 32'sh2400_0000);
        if (r < 85)
            return coord_t'($urandom);
        return coord_t'(int'($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
    endfunction

    // ------------------------------------------------------------------
    // Point stream and result checking
    // ------------------------------------------------------------------

    // Offer one point; predict its escape once the request is taken.
    // Leave s_tvalid high afterward so a back-to-back point needs no toggle.
    task automatic offer_point(input coord_t c_re, input coord_t c_im);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom};
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c_im, c_re};
        do
            @(posedge clk);
        while (!s_tready);
        expected_escapes.push_back(predict_escape(c_re, c_im));
        points_sent++;
    endtask

    // Drop the point stream and hold until every expected result is back.
    task automatic await_all_escapes();
        s_tvalid <= 1'b0;
        while (expected_escapes.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random ready gaps, plus a long hold-off on request.
    initial
    begin
        int unsigned idle;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold_cycles != 0)
            begin
                m_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
            end
            else
            begin
                idle = pick_gap();
                if (idle == 0)
                begin
                    m_tready <= 1'b1;
                    @(posedge clk);
                end
                else
                begin
                    m_tready <= 1'b0;
                    repeat (idle) @(posedge clk);
                end
            end
        end
    end

    // Compare every accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        escape_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (expected_escapes.size() == 0)
            begin
                mismatch_count++;
                $error("unexpected result: escape_count %0d, escaped %0b",
                       m_tdata[COUNT_BITS-1:0], m_tuser);
            end
            else
            begin
                want = expected_escapes.pop_front();
                if (m_tdata[COUNT_BITS-1:0] !== want.count)
                begin
                    mismatch_count++;
                    $error("escape_count: expected %0d, actual %0d",
                           want.count, m_tdata[COUNT_BITS-1:0]);
                end
                if (m_tuser !== want.escaped)
                begin
                    mismatch_count++;
                    $error("escaped: expected %0b, actual %0b", want.escaped, m_tuser);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // APB register access
    // ------------------------------------------------------------------

    // Setup cycle, then access cycle until pready; return prdata of the access.
    task automatic apb_access(input logic wr, input reg_idx_t idx,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Write one register and mirror the block's acceptance rules:
    // a zero limit or a degree outside 2..MAX_DEGREE leaves the old value.
    task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] unused;
        apb_access(1'b1, idx, value, unused);
        if (idx == REG_MAX_ITER)
        begin
            if (value[COUNT_BITS-1:0] != '0)
                cfg_max_iter = value[COUNT_BITS-1:0];
        end
        else if (value[DEGREE_W-1:0] >= 2 && value[DEGREE_W-1:0] <= MAX_DEGREE)
            cfg_degree = value[DEGREE_W-1:0];
    endtask

    // Read both registers back against the shadow copy.
    task automatic check_regs();
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b0, REG_MAX_ITER, '0, rd);
        if (rd[COUNT_BITS-1:0] !== cfg_max_iter)
        begin
            mismatch_count++;
            $error("max_iterations: expected %0d, actual %0d", cfg_max_iter, rd[COUNT_BITS-1:0]);
        end
        apb_access(1'b0, REG_DEGREE, '0, rd);
        if (rd[DEGREE_W-1:0] !== cfg_degree)
        begin
            mismatch_count++;
            $error("degree: expected %0d, actual %0d", cfg_degree, rd[DEGREE_W-1:0]);
        end
    endtask

    // Load a new setting (only while idle) and confirm it.
    task automatic set_registers(input logic [APB_DATA_W-1:0] iter_word,
                                 input logic [APB_DATA_W-1:0] degree_word);
        write_reg(REG_MAX_ITER, iter_word);
        write_reg(REG_DEGREE, degree_word);
        check_regs();
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_reset_values();
        check_regs();
        settings_used++;
    endtask

    task automatic test_directed_points();
        // Reset setting: limit 256, degree 2
        offer_point(Q_ZERO, Q_ZERO);          // bounded, runs the full limit
        offer_point(Q_NEG_TWO, Q_ZERO);       // sits exactly on |z|^2 = 4, never escapes
        offer_point(Q_MAX, Q_MAX);            // escapes on the first iteration
        offer_point(Q_MIN, Q_MIN);
        offer_point(Q_MIN, Q_MAX);
        offer_point(Q_MAX, Q_MIN);
        offer_point(Q_0_26, Q_ZERO);          // slow escape past the cusp
        offer_point(Q_NEG_3Q, Q_TENTH);       // slow escape through the neck
        offer_point(Q_ZERO, Q_ONE);           // periodic orbit, bounded
        offer_point(Q_TWO, Q_ZERO);           // |c|^2 == 4 is not an escape yet
        offer_point(Q_ZERO, -Q_TWO);
        await_all_escapes();

        // Largest limit and degree; only points that leave early
        set_registers(32'h0000_FFFF, MAX_DEGREE);
        offer_point(Q_NEG_TWO, Q_ZERO);       // z^8 overflows the coordinate range
        offer_point(Q_ONE_P5, Q_ZERO);
        offer_point(Q_1_2, Q_0_9);
        offer_point(Q_MAX, Q_ZERO);
        await_all_escapes();

        // Smallest limit
        set_registers(32'h0000_0001, 32'h0000_0002);
        offer_point(Q_ZERO, Q_ZERO);
        offer_point(Q_TWO_P5, Q_ZERO);
        offer_point(Q_1_9, Q_ZERO);
        offer_point(Q_ZERO, -Q_1_9);
        await_all_escapes();

        // Highest degree with bounded points
        set_registers(32'h0000_0064, MAX_DEGREE);
        offer_point(Q_ZERO, Q_ZERO);
        offer_point(Q_NEG_3Q, Q_TENTH);
        await_all_escapes();
    endtask

    task automatic test_register_rules();
        // All of these must leave the registers untouched
        write_reg(REG_MAX_ITER, 32'h0000_0000);
        write_reg(REG_MAX_ITER, 32'h0001_0000);   // zero once masked to 16 bits
        write_reg(REG_DEGREE, 32'h0000_0000);
        write_reg(REG_DEGREE, 32'h0000_0001);
        write_reg(REG_DEGREE, 32'h0000_0009);
        write_reg(REG_DEGREE, 32'h0000_000F);
        write_reg(REG_DEGREE, 32'hFFFF_FFF0);
        check_regs();
        // Upper bits are dropped before the range check
        write_reg(REG_DEGREE, 32'h0000_0013);
        write_reg(REG_MAX_ITER, 32'hABCD_0007);
        check_regs();
        settings_used++;
        offer_point(Q_ZERO, Q_ZERO);
        offer_point(Q_0_26, Q_ZERO);
        offer_point(rand_coord(), rand_coord());
        await_all_escapes();
    endtask

    // Stall the receiver for a long stretch while points keep coming, so the
    // output register and the sequencer fill and s_tready drops.
    task automatic test_output_backpressure();
        set_registers(32'h0000_0010, 32'h0000_0003);
        rx_hold_cycles = 400;
        for (int n = 0; n < 8; n++)
        begin
            if (n % 3 == 1)
                offer_point(Q_ZERO, Q_ZERO);
            else
                offer_point(Q_MAX, coord_t'($urandom));
        end
        await_all_escapes();
    endtask

    // Phases of random points, each under its own register setting.
    task automatic test_random_points();
        logic [DEGREE_W-1:0]   deg;
        logic [COUNT_BITS-1:0] iters;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
                deg = 4'd2;
            else if (phase == 1)
                deg = DEGREE_W'(MAX_DEGREE);
            else
                deg = DEGREE_W'($urandom_range(2, MAX_DEGREE));
            iters = (phase == 2) ? 16'd1 : 16'($urandom_range(2, 32));
            // Sometimes try a rejected write first
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_DEGREE, {28'($urandom), 4'($urandom_range(MAX_DEGREE + 1, 15))});
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_MAX_ITER, {16'($urandom), 16'h0000});
            set_registers({16'($urandom), iters}, {28'($urandom), deg});
            no_idle = (phase % 4 == 3);
            for (int n = 0; n < POINTS_PER_PHASE; n++)
                offer_point(rand_coord(), rand_coord());
            await_all_escapes();
            no_idle = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_directed_points();
        test_register_rules();
        test_output_backpressure();
        test_random_points();

        // Let any stray result surface before the verdict
        repeat (100) @(posedge clk);

        $display("Checked %0d escape results for %0d points under %0d register settings.",
                 results_seen, points_sent, settings_used);
        $display("Degrees 2..%0d, limits 1..65535, rejected writes and long output stalls.",
                 MAX_DEGREE);
        if (mismatch_count == 0)
            $display("multibrot_escape_time_test: PASS");
        else
            $display("multibrot_escape_time_test: FAIL");
        $finish;
    end

    // Watchdog, several times the slowest legal run
    initial
    begin
        #30_000_000;
        $display("multibrot_escape_time_test: FAIL");
        $finish;
    end

endmodule
